// ===== hw/rtl/pal16_pkg.sv =====
// Shared constants, types and the scale8 helper for the 16-entry palette lookup.
// No dependencies; imported by pal16_mix and the top level.
package pal16_pkg;

	localparam int PAL_DEPTH  = 16;
	localparam int PAL_AW     = $clog2(PAL_DEPTH);
	localparam int CHAN_W     = 8;
	localparam int RGB_W      = 3 * CHAN_W;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = RGB_W;

	localparam int POS_LSB  = 12;
	localparam int FRAC_LSB = 4;

	localparam logic [PAL_AW-1:0] LAST_ENTRY = PAL_AW'(PAL_DEPTH - 1);
	localparam logic [CHAN_W-1:0] FULL8      = 8'hFF;

	// 1: scale8 is (x*(s+1))>>8, 0: (x*s)>>8 with +1 after dimming
	localparam logic SCALE_FIXED = 1'b1;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_WRITE  = 1'b1;

	typedef struct packed {
		logic              blend;
		logic [CHAN_W-1:0] frac;
		logic [CHAN_W-1:0] bright;
	} pal16_ctl_t;

	function automatic logic [CHAN_W-1:0] scale8(input logic [CHAN_W-1:0] x,
			input logic [CHAN_W-1:0] s);
		logic [CHAN_W:0]     m;
		logic [2*CHAN_W:0]   p;
		m = SCALE_FIXED ? ({1'b0, s} + 9'd1) : {1'b0, s};
		p = {9'd0, x} * {8'd0, m};
		return p[2*CHAN_W-1:CHAN_W];
	endfunction

endpackage

// ===== hw/rtl/pal16_mix.sv =====
// Blend and brightness datapath: two register stages after the palette read.
// Depends on pal16_pkg (scale8, pal16_ctl_t).
module pal16_mix import pal16_pkg::*; (
	input  logic             clk,
	input  logic             adv,
	input  logic [RGB_W-1:0] c1,
	input  logic [RGB_W-1:0] c2,
	input  pal16_ctl_t       ctl,
	output logic [RGB_W-1:0] rgb
);

	logic [RGB_W-1:0]  blend_d;
	logic [RGB_W-1:0]  blend_s2;
	logic [CHAN_W-1:0] bright_s2;
	logic [RGB_W-1:0]  dim_d;
	logic [RGB_W-1:0]  rgb_q;
	logic [CHAN_W-1:0] b_inc;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (ctl.blend) begin
				blend_d[k*CHAN_W +: CHAN_W] = scale8(c1[k*CHAN_W +: CHAN_W], FULL8 - ctl.frac)
					+ scale8(c2[k*CHAN_W +: CHAN_W], ctl.frac);
			end else begin
				blend_d[k*CHAN_W +: CHAN_W] = c1[k*CHAN_W +: CHAN_W];
			end
		end
	end

	// brightness 255 passes through, so b+1 never wraps on the dim path
	assign b_inc = bright_s2 + 8'd1;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (bright_s2 == FULL8) begin
				dim_d[k*CHAN_W +: CHAN_W] = blend_s2[k*CHAN_W +: CHAN_W];
			end else if (bright_s2 == '0 || blend_s2[k*CHAN_W +: CHAN_W] == '0) begin
				dim_d[k*CHAN_W +: CHAN_W] = '0;
			end else begin
				dim_d[k*CHAN_W +: CHAN_W] = scale8(blend_s2[k*CHAN_W +: CHAN_W], b_inc)
					+ (SCALE_FIXED ? 8'd0 : 8'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			blend_s2  <= blend_d;
			bright_s2 <= ctl.bright;
			rgb_q     <= dim_d;
		end
	end

	assign rgb = rgb_q;

endmodule

// ===== hw/rtl/palette16_interpolated_lookup.sv =====
// Top level: 16-entry RGB palette memory with blended, dimmed lookup.
// Depends on pal16_pkg and pal16_mix.
//
//  channel   | group                        | moves
//  ----------+------------------------------+---------------------------------
//  input     | s_tvalid/s_tready/s_tdata/   | palette write or lookup
//            | s_tuser                      |
//  output    | m_tvalid/m_tready/m_tdata    | one RGB result per lookup
//  config    | blend_enable_we/_wdata       | blend enable register
//
// One transaction per cycle unless the output stalls; a lookup result passes the palette
// read, blend and dim multiply registers in turn. A write lands in the palette at its
// accept edge, so a lookup in the next cycle sees it. The palette has two read ports.
// Reset clears the entry valid bits (palette reads black) and sets blend on.
// While the output holds an untaken result, the whole pipeline and input stall.
module palette16_interpolated_lookup import pal16_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  blend_enable_we,
	input  logic                  blend_enable_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// entry_number[3:0], entry_color[27:4], color_index[43:28], brightness[51:44], zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// opcode
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// red_out[7:0], green_out[15:8], blue_out[23:16]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	logic                  adv;
	logic                  acc;
	logic [PAL_AW-1:0]     in_num;
	logic [RGB_W-1:0]      in_color;
	logic [15:0]           in_index;
	logic [CHAN_W-1:0]     in_bright;
	logic [PAL_AW-1:0]     hi;
	logic [PAL_AW-1:0]     hi_nxt;
	logic [CHAN_W-1:0]     frac;

	logic                  blend_enable_q;
	logic [PAL_DEPTH-1:0]  ent_vld_q;
	logic [RGB_W-1:0]      pal_mem [PAL_DEPTH];
	logic [RGB_W-1:0]      rd1_s1;
	logic [RGB_W-1:0]      rd2_s1;
	logic                  rv1_s1;
	logic                  rv2_s1;
	logic                  v_s1;
	logic                  v_s2;
	logic                  m_tvalid_q;
	pal16_ctl_t            ctl_s1;
	logic [RGB_W-1:0]      c1;
	logic [RGB_W-1:0]      c2;
	logic [RGB_W-1:0]      rgb;

	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv;
	assign acc      = s_tvalid && adv;

	assign in_num    = s_tdata[3:0];
	assign in_color  = s_tdata[27:4];
	assign in_index  = s_tdata[43:28];
	assign in_bright = s_tdata[51:44];

	assign hi     = in_index[POS_LSB +: PAL_AW];
	assign frac   = in_index[FRAC_LSB +: CHAN_W];
	assign hi_nxt = (hi == LAST_ENTRY) ? '0 : hi + 1'b1;

	always_ff @(posedge clk) begin
		if (acc && s_tuser == OP_WRITE) begin
			pal_mem[in_num] <= in_color;
		end
		if (adv) begin
			rd1_s1        <= pal_mem[hi];
			rd2_s1        <= pal_mem[hi_nxt];
			ctl_s1.blend  <= blend_enable_q && (frac != '0);
			ctl_s1.frac   <= frac;
			ctl_s1.bright <= in_bright;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_enable_q <= 1'b1;
			ent_vld_q      <= '0;
			rv1_s1         <= 1'b0;
			rv2_s1         <= 1'b0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (blend_enable_we) begin
				blend_enable_q <= blend_enable_wdata;
			end
			if (acc && s_tuser == OP_WRITE) begin
				ent_vld_q[in_num] <= 1'b1;
			end
			if (adv) begin
				rv1_s1     <= ent_vld_q[hi];
				rv2_s1     <= ent_vld_q[hi_nxt];
				v_s1       <= acc && (s_tuser == OP_LOOKUP);
				v_s2       <= v_s1;
				m_tvalid_q <= v_s2;
			end
		end
	end

	// never-written entries read as black
	assign c1 = rv1_s1 ? rd1_s1 : '0;
	assign c2 = rv2_s1 ? rd2_s1 : '0;

	pal16_mix u_mix (
		.clk (clk),
		.adv (adv),
		.c1  (c1),
		.c2  (c2),
		.ctl (ctl_s1),
		.rgb (rgb)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {rgb[7:0], rgb[15:8], rgb[23:16]};

endmodule

// ===== hw/rtl/pal16_chk.sv =====
// Port-level checker for palette16_interpolated_lookup, bound to the top level.
// Depends only on the top level's ports.
module pal16_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [55:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("output transaction changed while stalled");

	// an empty output never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// zero brightness lookup gives black at the output when not stalled
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tuser && s_tdata[51:44] == 8'd0 && m_tready)
		##1 m_tready ##1 m_tready |=> (m_tvalid && m_tdata == 24'd0))
		else $error("zero brightness lookup not black");

	// write followed by an unblended full-brightness lookup of the same entry
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser)
		##1 (s_tvalid && s_tready && !s_tuser && m_tready
			&& s_tdata[43:40] == $past(s_tdata[3:0])
			&& s_tdata[39:32] == 8'd0 && s_tdata[51:44] == 8'hFF)
		##1 m_tready ##1 m_tready
		|=> (m_tvalid && m_tdata[7:0] == $past(s_tdata[27:20], 4)
			&& m_tdata[15:8] == $past(s_tdata[19:12], 4)
			&& m_tdata[23:16] == $past(s_tdata[11:4], 4)))
		else $error("palette write not read back");

endmodule

bind palette16_interpolated_lookup pal16_chk u_pal16_chk (.*);
